FILE: rtl/char_lcd_bus_sequencer_assert.svh
// Assertion macros for the character LCD bus sequencer.
`ifndef CHAR_LCD_BUS_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_BUS_SEQUENCER_ASSERT_SVH

// Property checked at every edge outside reset.
`define CLBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define CLBS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: rtl/clbs_pkg.sv
// Shared types, codes, constants and tables of the character LCD bus sequencer.
package clbs_pkg;

  localparam int CLBS_MAX_ROWS    = 4;
  localparam int CLBS_QUEUE_DEPTH = 2;

  // request codes
  localparam logic [2:0] OP_INIT   = 3'd0;
  localparam logic [2:0] OP_CMD    = 3'd1;
  localparam logic [2:0] OP_CHAR   = 3'd2;
  localparam logic [2:0] OP_CURSOR = 3'd3;
  localparam logic [2:0] OP_GLYPH  = 3'd4;

  // register indexes
  localparam logic [2:0] CFG_NIBBLE_MODE = 3'd0;
  localparam logic [2:0] CFG_WIDE_LAYOUT = 3'd1;
  localparam logic [2:0] CFG_ROW_COUNT   = 3'd2;
  localparam logic [2:0] CFG_TALL_FONT   = 3'd3;

  // hold times, us
  localparam logic [10:0] HOLD_SHORT  = 11'd1;
  localparam logic [10:0] HOLD_PULSE8 = 11'd10;
  localparam logic [10:0] HOLD_CMD    = 11'd2000;
  localparam logic [10:0] HOLD_CHAR   = 11'd50;

  localparam logic [7:0] WAKE_BYTE    = 8'h30;
  localparam logic [7:0] CGRAM_BASE   = 8'h40;
  localparam logic [7:0] INIT8_FUNC   = 8'h38;
  localparam logic [7:0] INIT4_FUNC_A = 8'h20;
  localparam logic [7:0] INIT4_HOME   = 8'h02;
  localparam logic [7:0] INIT4_FUNC_B = 8'h28;
  localparam logic [7:0] INIT_DISPLAY = 8'h0c;
  localparam logic [7:0] INIT_ENTRY   = 8'h06;

  localparam logic [2:0] PH_LAST_NIB    = 3'd4;
  localparam logic [2:0] PH_LAST_BYTE   = 3'd2;
  localparam logic [2:0] INIT_LAST_NIB  = 3'd4;
  localparam logic [2:0] INIT_LAST_BYTE = 3'd2;
  localparam logic [2:0] WAKE_LAST      = 3'd5;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_BYTE,
    JOB_INIT
  } job_kind_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_WAKE,
    SQ_BYTE
  } seq_state_t;

  typedef struct packed {
    logic       nibble_mode;
    logic       wide_layout;
    logic [2:0] row_count;
    logic       tall_font;
  } cfg_t;

  typedef struct packed {
    job_kind_t  kind;
    logic [7:0] byte_val;
    logic       rs;
    logic       char_wait;
    logic       nib;
  } job_t;

  typedef struct packed {
    logic [7:0]  data_bus;
    logic        reg_select;
    logic        enable;
    logic [10:0] hold_us;
    logic        error;
    logic        last;
  } bus_word_t;

  function automatic logic [7:0] row_base(input logic [1:0] line, input logic wide);
    logic [7:0] b;
    case (line)
      2'd0:    b = 8'h80;
      2'd1:    b = 8'hc0;
      2'd2:    b = wide ? 8'h94 : 8'h90;
      default: b = wide ? 8'hd4 : 8'hd0;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] init_byte(input logic [2:0] idx, input logic nib);
    logic [7:0] b;
    if (nib) begin
      case (idx)
        3'd0:    b = INIT4_FUNC_A;
        3'd1:    b = INIT4_HOME;
        3'd2:    b = INIT4_FUNC_B;
        3'd3:    b = INIT_DISPLAY;
        default: b = INIT_ENTRY;
      endcase
    end else begin
      case (idx)
        3'd0:    b = INIT8_FUNC;
        3'd1:    b = INIT_DISPLAY;
        default: b = INIT_ENTRY;
      endcase
    end
    return b;
  endfunction

  // one bus state of a byte transfer; phase counts from the first enable high
  function automatic bus_word_t byte_word(input logic nib, input logic [7:0] b,
                                          input logic rs, input logic chr,
                                          input logic [2:0] ph);
    bus_word_t   w;
    logic [7:0]  hi;
    logic [7:0]  lo;
    logic [10:0] wt;
    hi = {b[7:4], 4'h0};
    lo = {b[3:0], 4'h0};
    wt = chr ? HOLD_CHAR : HOLD_CMD;
    w  = '0;
    w.reg_select = rs;
    if (nib) begin
      case (ph)
        3'd0: begin w.data_bus = hi; w.enable = 1'b1; w.hold_us = HOLD_SHORT; end
        3'd1: begin w.data_bus = hi; w.hold_us = HOLD_SHORT; end
        3'd2: begin w.data_bus = lo; w.enable = 1'b1; w.hold_us = HOLD_SHORT; end
        3'd3: begin w.data_bus = lo; w.hold_us = HOLD_SHORT; end
        default: begin w.data_bus = lo; w.hold_us = wt; end
      endcase
    end else begin
      case (ph)
        3'd0: begin w.data_bus = b; w.enable = 1'b1; w.hold_us = HOLD_PULSE8; end
        3'd1: begin w.data_bus = b; w.hold_us = HOLD_SHORT; end
        default: begin w.data_bus = b; w.hold_us = wt; end
      endcase
    end
    return w;
  endfunction

endpackage

FILE: rtl/clbs_front.sv
// Request decoder: range checks and address mapping into queue jobs.
module clbs_front import clbs_pkg::*; #(
  parameter int MAX_ROWS = CLBS_MAX_ROWS
) (
  input  cfg_t       cfg,
  input  logic [2:0] op,
  input  logic [7:0] value,
  input  logic [4:0] column,
  input  logic [1:0] line,
  input  logic [2:0] glyph_slot,
  output job_t       job
);

  localparam logic [2:0] MaxRowsW = 3'(MAX_ROWS);

  logic [2:0] rows;
  logic [4:0] cols;

  assign rows = (cfg.row_count > MaxRowsW) ? MaxRowsW : cfg.row_count;
  assign cols = cfg.wide_layout ? 5'd20 : 5'd16;

  always_comb begin
    job           = '0;
    job.kind      = JOB_ERR;
    job.nib       = cfg.nibble_mode;
    unique case (op)
      OP_INIT: job.kind = JOB_INIT;
      OP_CMD: begin
        job.kind     = JOB_BYTE;
        job.byte_val = value;
      end
      OP_CHAR: begin
        job.kind      = JOB_BYTE;
        job.byte_val  = value;
        job.rs        = 1'b1;
        job.char_wait = 1'b1;
      end
      OP_CURSOR: begin
        if (column < cols && {1'b0, line} < rows) begin
          job.kind     = JOB_BYTE;
          job.byte_val = row_base(line, cfg.wide_layout) + {3'b000, column};
        end
      end
      OP_GLYPH: begin
        if (cfg.tall_font) begin
          if (glyph_slot <= 3'd3) begin
            job.kind     = JOB_BYTE;
            job.byte_val = CGRAM_BASE | {2'b00, glyph_slot[1:0], 4'h0};
          end
        end else begin
          job.kind     = JOB_BYTE;
          job.byte_val = CGRAM_BASE | {2'b00, glyph_slot, 3'b000};
        end
      end
      default: job.kind = JOB_ERR;
    endcase
  end

endmodule

FILE: rtl/clbs_queue.sv
// Short job queue between decoder and bus sequencer.
module clbs_queue import clbs_pkg::*; #(
  parameter int DEPTH = CLBS_QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic empty,
  output logic full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/clbs_back.sv
// Bus sequencer: expands jobs into bus state words, one per cycle unless the output stalls.
module clbs_back import clbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      head,
  input  logic      head_valid,
  output logic      pop,
  input  logic      out_stall,
  output logic      out_valid,
  output bus_word_t out_word
);

  seq_state_t state_r, state_nxt;
  logic [2:0] phase_r, phase_nxt;
  logic [2:0] wake_r, wake_nxt;
  logic [2:0] idx_r, idx_nxt;
  job_t       cur_r, cur_nxt;
  logic       out_valid_r;
  bus_word_t  out_r;

  logic       can_emit;
  logic       emit_valid;
  bus_word_t  emit_word;
  logic [2:0] last_ph;
  logic [2:0] last_idx;
  logic       byte_done;
  logic       seq_done;
  bus_word_t  err_word;
  bus_word_t  wake_word;

  assign can_emit  = !out_valid_r || !out_stall;
  assign last_ph   = cur_r.nib ? PH_LAST_NIB : PH_LAST_BYTE;
  assign last_idx  = cur_r.nib ? INIT_LAST_NIB : INIT_LAST_BYTE;
  assign byte_done = (phase_r == last_ph);
  assign seq_done  = byte_done && (cur_r.kind != JOB_INIT || idx_r == last_idx);

  always_comb begin
    err_word       = '0;
    err_word.error = 1'b1;
    err_word.last  = 1'b1;
  end

  // wake-up pulses: 0x30, enable high on even steps
  always_comb begin
    wake_word          = '0;
    wake_word.data_bus = WAKE_BYTE;
    wake_word.hold_us  = HOLD_SHORT;
    wake_word.enable   = (state_r == SQ_WAKE) ? ~wake_r[0] : 1'b1;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    wake_nxt  = wake_r;
    idx_nxt   = idx_r;
    cur_nxt   = cur_r;
    if (can_emit) begin
      unique case (state_r)
        SQ_IDLE: begin
          if (head_valid) begin
            cur_nxt = head;
            case (head.kind)
              JOB_BYTE: begin
                state_nxt = SQ_BYTE;
                phase_nxt = 3'd1;
              end
              JOB_INIT: begin
                if (head.nib) begin
                  state_nxt = SQ_WAKE;
                  wake_nxt  = 3'd1;
                end else begin
                  state_nxt        = SQ_BYTE;
                  phase_nxt        = 3'd1;
                  idx_nxt          = 3'd0;
                  cur_nxt.byte_val = init_byte(3'd0, 1'b0);
                end
              end
              default: state_nxt = SQ_IDLE;
            endcase
          end
        end
        SQ_WAKE: begin
          if (wake_r == WAKE_LAST) begin
            state_nxt        = SQ_BYTE;
            phase_nxt        = 3'd0;
            idx_nxt          = 3'd0;
            cur_nxt.byte_val = init_byte(3'd0, 1'b1);
          end else begin
            wake_nxt = wake_r + 3'd1;
          end
        end
        SQ_BYTE: begin
          if (seq_done) begin
            state_nxt = SQ_IDLE;
          end else if (byte_done) begin
            phase_nxt        = 3'd0;
            idx_nxt          = idx_r + 3'd1;
            cur_nxt.byte_val = init_byte(idx_r + 3'd1, cur_r.nib);
          end else begin
            phase_nxt = phase_r + 3'd1;
          end
        end
        default: state_nxt = SQ_IDLE;
      endcase
    end
  end

  // emitted word and queue pop
  always_comb begin
    emit_valid = 1'b0;
    emit_word  = '0;
    unique case (state_r)
      SQ_IDLE: begin
        if (head_valid) begin
          emit_valid = 1'b1;
          case (head.kind)
            JOB_BYTE: emit_word = byte_word(head.nib, head.byte_val, head.rs,
                                            head.char_wait, 3'd0);
            JOB_INIT: begin
              if (head.nib) begin
                emit_word = wake_word;
              end else begin
                emit_word = byte_word(1'b0, init_byte(3'd0, 1'b0), 1'b0, 1'b0, 3'd0);
              end
            end
            default: emit_word = err_word;
          endcase
        end
      end
      SQ_WAKE: begin
        emit_valid = 1'b1;
        emit_word  = wake_word;
      end
      SQ_BYTE: begin
        emit_valid     = 1'b1;
        emit_word      = byte_word(cur_r.nib, cur_r.byte_val, cur_r.rs,
                                   cur_r.char_wait, phase_r);
        emit_word.last = seq_done;
      end
      default: emit_valid = 1'b0;
    endcase
    pop = can_emit && (state_r == SQ_IDLE) && head_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SQ_IDLE;
      phase_r     <= '0;
      wake_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      wake_r      <= wake_nxt;
      idx_r       <= idx_nxt;
      if (can_emit) begin
        out_valid_r <= emit_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (can_emit) begin
      out_r <= emit_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_r;

endmodule

FILE: rtl/char_lcd_bus_sequencer.sv
// Character LCD bus sequencer: top level with registers, decoder, queue and sequencer.
//
// Input channel (in_*): one request word per handshake: init, command byte,
// character byte, set cursor or select glyph slot. Accepted when in_valid is
// high and in_stall low. in_stall rises only when the job queue is full.
// Output channel (out_*): one bus state word per handshake (data lines,
// register select, read/write, enable, hold time). out_last marks the final
// word of a request; a rejected request gives one word with out_error set.
// Words per request: 5 for a 4-bit byte, 3 for an 8-bit byte, 31 / 9 for
// init in 4-bit / 8-bit mode, 1 for an error.
// The first word passes through the job queue and then the output register.
// Throughput: one word per cycle from the sequencer unless out_stall holds the
// output; after the last word of a job the sequencer returns to idle and pops the next job.
// The decoder keeps accepting while the queue has room, even with the
// output stalled. Under out_stall the output register holds its word and
// the sequencer waits.
// Configuration (cfg_*): write only; the user must write it only while idle,
// which the block itself does not enforce. After reset the registers read 4-bit
// mode, 16-column layout, two rows, 5x8 font; queue and output register are empty.
module char_lcd_bus_sequencer import clbs_pkg::*; #(
  parameter int MAX_ROWS    = CLBS_MAX_ROWS,
  parameter int QUEUE_DEPTH = CLBS_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [2:0]  cfg_wdata,
  // requests
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [7:0]  in_value,
  input  logic [4:0]  in_column,
  input  logic [1:0]  in_line,
  input  logic [2:0]  in_glyph_slot,
  // bus state words
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_bus,
  output logic        out_reg_select,
  output logic        out_read_write,
  output logic        out_enable,
  output logic [10:0] out_hold_us,
  output logic        out_error,
  output logic        out_last
);

  cfg_t      cfg_r;
  job_t      front_job;
  job_t      head;
  logic      q_empty;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  bus_word_t word;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.nibble_mode <= 1'b1;
      cfg_r.wide_layout <= 1'b0;
      cfg_r.row_count   <= 3'd2;
      cfg_r.tall_font   <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NIBBLE_MODE: cfg_r.nibble_mode <= cfg_wdata[0];
        CFG_WIDE_LAYOUT: cfg_r.wide_layout <= cfg_wdata[0];
        CFG_ROW_COUNT:   cfg_r.row_count   <= cfg_wdata;
        CFG_TALL_FONT:   cfg_r.tall_font   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // front: classify request
  clbs_front #(
    .MAX_ROWS (MAX_ROWS)
  ) u_front (
    .cfg        (cfg_r),
    .op         (in_op),
    .value      (in_value),
    .column     (in_column),
    .line       (in_line),
    .glyph_slot (in_glyph_slot),
    .job        (front_job)
  );

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  clbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (front_job),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // back: bus state sequencing with output register
  clbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .head_valid (!q_empty),
    .pop        (q_pop),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_word   (word)
  );

  assign out_data_bus   = word.data_bus;
  assign out_reg_select = word.reg_select;
  assign out_read_write = 1'b0;
  assign out_enable     = word.enable;
  assign out_hold_us    = word.hold_us;
  assign out_error      = word.error;
  assign out_last       = word.last;

`include "char_lcd_bus_sequencer_assert.svh"

  // an error word is a bare terminator
  `CLBS_ASSERT(a_err_word, !(out_valid && out_error) || (out_last && !out_enable && out_hold_us == 11'd0 && out_data_bus == 8'd0), "error word malformed")
  // a strobe is never the final state of a request
  `CLBS_ASSERT(a_strobe_not_last, !(out_valid && out_enable) || !out_last, "enable high on last word")
  // a taken strobe word is followed at once by the strobe release
  `CLBS_ASSERT_NEXT(a_strobe_release, out_valid && !out_stall && out_enable, out_valid && !out_enable && !out_error, "enable pulse not released")

endmodule
